/* src/assert_macros.svh */
// assertion macros, used by the rtl top file
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cle_pkg.sv */
// types and constants of the console line editor with command match
// no dependencies
package cle_pkg;

    localparam int NUM_KEYS = 7;
    localparam int KEY_MAX  = 8;

    localparam logic [1:0] KIND_ECHO    = 2'd0;
    localparam logic [1:0] KIND_KNOWN   = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_ZERO  = 8'h00;

    // keyword text, zero padded, in command index order
    localparam logic [7:0] KEY_TEXT [NUM_KEYS][KEY_MAX] = '{
        '{"h", "e", "l", "p", CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO},
        '{"p", "s", CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO},
        '{"t", "o", "p", CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO},
        '{"t", "i", "c", "k", CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO},
        '{"m", "e", "m", "s", "t", "a", "t", CH_ZERO},
        '{"s", "e", "m", "s", "t", "a", "t", CH_ZERO},
        '{"q", "u", "i", "t", CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO}
    };

    localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{3'd4, 3'd2, 3'd3, 3'd4, 3'd7, 3'd7, 3'd4};

    typedef enum logic [3:0] {
        S_IDLE,
        S_ECHO,
        S_BS1,
        S_BS2,
        S_BS3,
        S_LF,
        S_TOK,
        S_SPC,
        S_RES
    } cle_state_t;

endpackage

/* src/cle_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/console_line_editor_command_match_top.sv */
// console line editor: line ram, fill count and end-of-line keyword match
// depends on cle_pkg, cle_ram and assert_macros.svh
//
// Takes one console byte per word and keeps the line in a LINE_DEPTH-byte ram.
// A printable byte, if the line has room, gives one echo word; an erase on a
// non-empty line gives three echo words (BS, space, BS). A line end gives an LF
// echo word and, for a non-empty line, a command word after a scan that reads one
// line byte per cycle from the ram read port: the token, then the spaces after it.
// Input is taken again as soon as the last word of a byte is in the output
// register.
`include "assert_macros.svh"

module console_line_editor_command_match_top
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH  = 128,
    parameter int TOKEN_LIMIT = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] echo_byte,
    output logic [2:0] command_index,
    output logic [6:0] args_start,
    output logic [6:0] line_length,
    output logic       last
);

    localparam int AW = $clog2(LINE_DEPTH);

    cle_state_t state_reg, state_next;

    logic [AW-1:0]       fill_reg, fill_next;
    logic [AW-1:0]       len_reg, len_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [NUM_KEYS-1:0] match_reg, match_next;
    logic [7:0]          echo_reg, echo_next;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_kind_reg, out_kind_next;
    logic [7:0] out_echo_reg, out_echo_next;
    logic [2:0] out_idx_reg, out_idx_next;
    logic [6:0] out_args_reg, out_args_next;
    logic [6:0] out_len_reg, out_len_next;
    logic       out_last_reg, out_last_next;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic slot_free;
    logic is_erase, is_eol, is_print, has_room;
    logic at_end, is_space, tok_end, skip_space;
    logic emit, e_last;
    logic [1:0] e_kind;
    logic [7:0] e_echo;
    logic [2:0] e_idx;
    logic [6:0] e_args, e_len;
    logic       any_hit;
    logic [2:0] hit_idx;

    cle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg),
        .wdata (rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready      = (state_reg == S_IDLE);
    assign slot_free     = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign echo_byte     = out_echo_reg;
    assign command_index = out_idx_reg;
    assign args_start    = out_args_reg;
    assign line_length   = out_len_reg;
    assign last          = out_last_reg;

    assign is_erase   = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
    assign is_eol     = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign is_print   = (rx_byte >= CH_SP) && (rx_byte < CH_DEL);
    assign has_room   = 32'(fill_reg) < LINE_DEPTH - 1;
    assign at_end     = (pos_reg == len_reg);
    assign is_space   = (ram_rdata == CH_SP);
    assign tok_end    = at_end || (32'(pos_reg) == TOKEN_LIMIT - 1) || is_space;
    assign skip_space = !at_end && is_space;
    assign ram_we     = in_valid && in_ready && is_print && has_room;
    assign ram_raddr  = (state_reg == S_TOK || state_reg == S_SPC) ? pos_reg + AW'(1) : '0;

    // first keyword hit
    always_comb
    begin
        any_hit = 1'b0;
        hit_idx = 3'd0;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (match_reg[k])
            begin
                any_hit = 1'b1;
                hit_idx = 3'(k);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (is_erase && fill_reg != '0)
                    begin
                        state_next = S_BS1;
                    end
                    else if (is_eol)
                    begin
                        state_next = S_LF;
                    end
                    else if (is_print && has_room)
                    begin
                        state_next = S_ECHO;
                    end
                end
            end
            S_ECHO: if (slot_free) state_next = S_IDLE;
            S_BS1:  if (slot_free) state_next = S_BS2;
            S_BS2:  if (slot_free) state_next = S_BS3;
            S_BS3:  if (slot_free) state_next = S_IDLE;
            S_LF:   if (slot_free) state_next = (len_reg == '0) ? S_IDLE : S_TOK;
            S_TOK:  if (tok_end) state_next = skip_space ? S_SPC : S_RES;
            S_SPC:  if (at_end || !is_space) state_next = S_RES;
            S_RES:  if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and output words
    always_comb
    begin
        fill_next  = fill_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        match_next = match_reg;
        echo_next  = echo_reg;
        emit       = 1'b0;
        e_kind     = KIND_ECHO;
        e_echo     = CH_ZERO;
        e_idx      = 3'd0;
        e_args     = 7'd0;
        e_len      = 7'd0;
        e_last     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (is_erase)
                    begin
                        if (fill_reg != '0)
                        begin
                            fill_next = fill_reg - AW'(1);
                        end
                    end
                    else if (is_eol)
                    begin
                        len_next   = fill_reg;
                        fill_next  = '0;
                        pos_next   = '0;
                        match_next = '1;
                    end
                    else if (is_print && has_room)
                    begin
                        fill_next = fill_reg + AW'(1);
                        echo_next = rx_byte;
                    end
                end
            end
            S_ECHO:
            begin
                emit   = 1'b1;
                e_echo = echo_reg;
                e_last = 1'b1;
            end
            S_BS1:
            begin
                emit   = 1'b1;
                e_echo = CH_BS;
            end
            S_BS2:
            begin
                emit   = 1'b1;
                e_echo = CH_SP;
            end
            S_BS3:
            begin
                emit   = 1'b1;
                e_echo = CH_BS;
                e_last = 1'b1;
            end
            S_LF:
            begin
                emit   = 1'b1;
                e_echo = CH_LF;
                e_last = (len_reg == '0);
            end
            S_TOK:
            begin
                if (tok_end)
                begin
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        match_next[k] = match_reg[k] && (32'(pos_reg) == 32'(KEY_LEN[k]));
                    end
                    if (skip_space)
                    begin
                        pos_next = pos_reg + AW'(1);
                    end
                end
                else
                begin
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        match_next[k] = match_reg[k] && (32'(pos_reg) < KEY_MAX)
                                        && (ram_rdata == KEY_TEXT[k][3'(pos_reg)]);
                    end
                    pos_next = pos_reg + AW'(1);
                end
            end
            S_SPC:
            begin
                if (!at_end && is_space)
                begin
                    pos_next = pos_reg + AW'(1);
                end
            end
            S_RES:
            begin
                emit   = 1'b1;
                e_kind = any_hit ? KIND_KNOWN : KIND_UNKNOWN;
                e_idx  = any_hit ? hit_idx : 3'd0;
                e_args = 7'(pos_reg);
                e_len  = 7'(len_reg);
                e_last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_echo_next  = out_echo_reg;
        out_idx_next   = out_idx_reg;
        out_args_next  = out_args_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        if (emit && slot_free)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = e_kind;
            out_echo_next  = e_echo;
            out_idx_next   = e_idx;
            out_args_next  = e_args;
            out_len_next   = e_len;
            out_last_next  = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        pos_reg      <= pos_next;
        match_reg    <= match_next;
        echo_reg     <= echo_next;
        out_kind_reg <= out_kind_next;
        out_echo_reg <= out_echo_next;
        out_idx_reg  <= out_idx_next;
        out_args_reg <= out_args_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    `ASSERT_ALWAYS(a_fill_room, 32'(fill_reg) < LINE_DEPTH, "line fill beyond line depth")
    `ASSERT_IMPLIES(a_scan_bound, (state_reg == S_TOK || state_reg == S_SPC), pos_reg <= len_reg, "scan position past line length")
    `ASSERT_IMPLIES(a_cmd_last, out_valid_reg && out_kind_reg != KIND_ECHO, out_last_reg, "command word not marked last")
    `ASSERT_NEXT(a_write_echo, ram_we, state_reg == S_ECHO, "stored byte not followed by its echo")

endmodule

/* test/testbench.sv */
// testbench for console_line_editor_command_match_top: console bytes in, echo and command words out
// depends on cle_pkg and the rtl under src; a directed table, then random lines checked by a line predictor
module testbench;
    import cle_pkg::*;

    localparam int LINE_DEPTH     = 128;
    localparam int TOKEN_LIMIT    = 16;
    localparam int ITEMS_TARGET   = 270;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SCRIPT_ROWS    = 24;

    typedef enum logic [2:0] {
        CMD_HELP,
        CMD_PS,
        CMD_TOP,
        CMD_TICK,
        CMD_MEMSTAT,
        CMD_SEMSTAT,
        CMD_QUIT
    } command_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] echo;
        logic [2:0] idx;
        logic [6:0] args;
        logic [6:0] len;
        logic       last;
    } line_word_t;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        int         count;
        line_word_t tail;
    } script_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] echo_byte;
    logic [2:0] command_index;
    logic [6:0] args_start;
    logic [6:0] line_length;
    logic       last;

    string       keywords [NUM_KEYS] = '{"help", "ps", "top", "tick", "memstat", "semstat", "quit"};
    logic [7:0]  line_buf [LINE_DEPTH];
    int unsigned line_fill = 0;
    line_word_t  step_words [$];
    line_word_t  due_console_words [$];
    logic [7:0]  line_bytes [$];
    script_row_t script_rows [SCRIPT_ROWS];

    int error_count   = 0;
    int bytes_taken   = 0;
    int bytes_counted = 0;
    int words_checked = 0;
    int known_seen    = 0;
    int unknown_seen  = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int keyword_turn  = 0;

    console_line_editor_command_match_top #(
        .LINE_DEPTH (LINE_DEPTH),
        .TOKEN_LIMIT(TOKEN_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .echo_byte    (echo_byte),
        .command_index(command_index),
        .args_start   (args_start),
        .line_length  (line_length),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic line_word_t echo_word(input logic [7:0] b, input logic fin);
        line_word_t w;
        w = '0;
        w.kind = KIND_ECHO;
        w.echo = b;
        w.last = fin;
        return w;
    endfunction

    function automatic line_word_t command_word(input logic [1:0] k, input logic [2:0] idx,
                                                input int args, input int len);
        line_word_t w;
        w = '0;
        w.kind = k;
        w.idx  = idx;
        w.args = args[6:0];
        w.len  = len[6:0];
        w.last = 1'b1;
        return w;
    endfunction

    // line editor state update and the words one byte causes
    function automatic void edit_line(input logic [7:0] b);
        int  tok;
        int  args;
        int  hit;
        bit  same;
        step_words.delete();
        if (b == CH_DEL || b == CH_BS)
        begin
            if (line_fill != 0)
            begin
                line_fill--;
                step_words.push_back(echo_word(CH_BS, 1'b0));
                step_words.push_back(echo_word(CH_SP, 1'b0));
                step_words.push_back(echo_word(CH_BS, 1'b1));
            end
        end
        else if (b == CH_CR || b == CH_LF)
        begin
            if (line_fill == 0)
                step_words.push_back(echo_word(CH_LF, 1'b1));
            else
            begin
                step_words.push_back(echo_word(CH_LF, 1'b0));
                tok = 0;
                while (tok < line_fill && line_buf[tok] != CH_SP && tok < TOKEN_LIMIT - 1)
                    tok++;
                args = tok;
                while (args < line_fill && line_buf[args] == CH_SP)
                    args++;
                hit = -1;
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    if (hit < 0 && keywords[k].len() == tok)
                    begin
                        same = 1'b1;
                        for (int i = 0; i < tok; i++)
                            if (line_buf[i] != keywords[k][i])
                                same = 1'b0;
                        if (same)
                            hit = k;
                    end
                end
                if (hit >= 0)
                    step_words.push_back(command_word(KIND_KNOWN, 3'(hit), args, line_fill));
                else
                    step_words.push_back(command_word(KIND_UNKNOWN, CMD_HELP, args, line_fill));
                line_fill = 0;
            end
        end
        else if (b >= CH_SP && b < CH_DEL)
        begin
            if (line_fill < LINE_DEPTH - 1)
            begin
                line_buf[line_fill] = b;
                line_fill++;
                step_words.push_back(echo_word(b, 1'b1));
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 50)
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // output side: random stalls and in-order compare
    always @(posedge clk)
    begin
        line_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (due_console_words.size() == 0)
                    report_mismatch("unexpected word, kind", kind, 0);
                else
                begin
                    want = due_console_words.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", kind, want.kind);
                    if (echo_byte !== want.echo)
                        report_mismatch("echo_byte", echo_byte, want.echo);
                    if (command_index !== want.idx)
                        report_mismatch("command_index", command_index, want.idx);
                    if (args_start !== want.args)
                        report_mismatch("args_start", args_start, want.args);
                    if (line_length !== want.len)
                        report_mismatch("line_length", line_length, want.len);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                    words_checked++;
                    if (want.kind == KIND_KNOWN)
                        known_seen++;
                    if (want.kind == KIND_UNKNOWN)
                        unknown_seen++;
                end
            end
            out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d quiet cycles, %0d words still due", quiet_cycles,
                     due_console_words.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit typed, input int count,
                             input line_word_t tail);
        while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        edit_line(b);
        if (typed)
        begin
            if (count == 2)
                due_console_words.push_back(echo_word(CH_LF, 1'b0));
            if (count >= 1)
                due_console_words.push_back(tail);
        end
        else
            foreach (step_words[i])
                due_console_words.push_back(step_words[i]);
        bytes_taken++;
        if (step_words.size() != 0)
            bytes_counted++;
    endtask

    task automatic drain_due();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_console_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_printable(input bit no_space);
        return 8'($urandom_range(no_space ? 8'h21 : 8'h20, 8'h7E));
    endfunction

    task automatic send_random_line(input int line_no);
        int    pick;
        int    n;
        string word;
        line_bytes.delete();
        pick = $urandom_range(0, 99);
        if (line_no == 2)
        begin
            // fill past the end, erase one, refill, then one more that is dropped
            repeat (LINE_DEPTH + 2) line_bytes.push_back(rand_printable(1'b0));
            line_bytes.push_back(CH_DEL);
            line_bytes.push_back(rand_printable(1'b0));
            line_bytes.push_back(rand_printable(1'b0));
        end
        else if (pick < 45)
        begin
            word = keywords[keyword_turn % NUM_KEYS];
            keyword_turn++;
            if ($urandom_range(0, 3) == 0)
            begin
                line_bytes.push_back(rand_printable(1'b1));
                line_bytes.push_back($urandom_range(0, 1) ? CH_BS : CH_DEL);
            end
            for (int i = 0; i < word.len(); i++)
                line_bytes.push_back(word[i]);
            repeat ($urandom_range(0, 3)) line_bytes.push_back(CH_SP);
            repeat ($urandom_range(0, 6)) line_bytes.push_back(rand_printable(1'b0));
        end
        else if (pick < 60)
        begin
            // near miss of a keyword
            word = keywords[$urandom_range(0, NUM_KEYS - 1)];
            n = $urandom_range(0, word.len() - 1);
            case ($urandom_range(0, 2))
                0: word[n] = rand_printable(1'b1);
                1: word = word.substr(0, word.len() - 2);
                default: word = {word, "x"};
            endcase
            for (int i = 0; i < word.len(); i++)
                line_bytes.push_back(word[i]);
            if ($urandom_range(0, 1))
            begin
                line_bytes.push_back(CH_SP);
                line_bytes.push_back(rand_printable(1'b1));
            end
        end
        else if (pick < 70)
        begin
            // token at and around the length limit
            repeat ($urandom_range(TOKEN_LIMIT - 3, TOKEN_LIMIT + 4))
                line_bytes.push_back(rand_printable(1'b1));
            repeat ($urandom_range(0, 2)) line_bytes.push_back(CH_SP);
            repeat ($urandom_range(0, 3)) line_bytes.push_back(rand_printable(1'b0));
        end
        else if (pick < 90)
        begin
            repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(0, 4);
            repeat (n) line_bytes.push_back(rand_printable(1'b0));
            repeat (n + $urandom_range(0, 2))
                line_bytes.push_back($urandom_range(0, 1) ? CH_BS : CH_DEL);
        end
        if (pick < 70 || pick >= 90 || $urandom_range(0, 1))
            line_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        foreach (line_bytes[i])
            send_byte(line_bytes[i], 1'b0, 0, '0);
    endtask

    initial
    begin
        int line_no;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = 8'h00;
        script_rows = '{
            '{CH_BS,   1'b1, 0, '0},
            '{CH_DEL,  1'b1, 0, '0},
            '{CH_CR,   1'b1, 1, echo_word(CH_LF, 1'b1)},
            '{8'h00,   1'b1, 0, '0},
            '{8'hFF,   1'b1, 0, '0},
            '{8'h80,   1'b1, 0, '0},
            '{8'h1F,   1'b1, 0, '0},
            '{CH_SP,   1'b1, 1, echo_word(CH_SP, 1'b1)},
            '{"p",     1'b0, 0, '0},
            '{"s",     1'b0, 0, '0},
            '{CH_CR,   1'b1, 2, command_word(KIND_UNKNOWN, CMD_HELP, 1, 3)},
            '{8'h7E,   1'b1, 1, echo_word(8'h7E, 1'b1)},
            '{CH_DEL,  1'b0, 0, '0},
            '{"q",     1'b0, 0, '0},
            '{"u",     1'b0, 0, '0},
            '{"i",     1'b0, 0, '0},
            '{"t",     1'b0, 0, '0},
            '{CH_LF,   1'b1, 2, command_word(KIND_KNOWN, CMD_QUIT, 4, 4)},
            '{"t",     1'b0, 0, '0},
            '{"o",     1'b0, 0, '0},
            '{"x",     1'b0, 0, '0},
            '{CH_BS,   1'b0, 0, '0},
            '{"p",     1'b0, 0, '0},
            '{CH_CR,   1'b1, 2, command_word(KIND_KNOWN, CMD_TOP, 3, 3)}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_rows[r])
            send_byte(script_rows[r].rx, script_rows[r].typed, script_rows[r].count,
                      script_rows[r].tail);
        drain_due();

        bytes_counted = 0;
        line_no = 0;
        while (bytes_counted < ITEMS_TARGET)
        begin
            case ((line_no / 4) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            if (line_no % 16 == 15)
                drain_due();
            send_random_line(line_no);
            line_no++;
        end

        drain_due();
        repeat (2 * LINE_DEPTH) @(posedge clk);
        $display("%0d console bytes sent over %0d random lines, %0d words checked",
                 bytes_taken, line_no, words_checked);
        $display("%0d known and %0d unknown commands, %0d mismatches",
                 known_seen, unknown_seen, error_count);
        if (error_count == 0 && due_console_words.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
